// ===== hw/rtl/mmp_pkg.sv =====
`timescale 1ns / 1ps

package mmp_pkg;

  // upper nibble codes of status bytes
  localparam logic [3:0] STATUS_NOTE_OFF   = 4'h8;
  localparam logic [3:0] STATUS_NOTE_ON    = 4'h9;
  localparam logic [3:0] STATUS_POLY_TOUCH = 4'hA;
  localparam logic [3:0] STATUS_CONTROL    = 4'hB;
  localparam logic [3:0] STATUS_PROGRAM    = 4'hC;
  localparam logic [3:0] STATUS_CHAN_TOUCH = 4'hD;
  localparam logic [3:0] STATUS_PITCH      = 4'hE;
  localparam logic [3:0] STATUS_SYSTEM     = 4'hF;

  // current message kind, held across running status
  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_NOTE_ON,
    KIND_NOTE_OFF,
    KIND_CTRL,
    KIND_UNIMPL
  } msg_kind_t;

  // where we are in a pair of data bytes
  typedef enum logic [1:0] {
    PHASE_IDLE,
    PHASE_FIRST,
    PHASE_SECOND
  } data_phase_t;

  // emitted event codes
  typedef enum logic [1:0] {
    EV_NOTE_ON,
    EV_NOTE_OFF,
    EV_CTRL
  } event_kind_t;

  typedef struct packed {
    msg_kind_t   kind;
    data_phase_t phase;
    logic [6:0]  held_first;
  } parser_state_t;

  typedef struct packed {
    logic        valid;
    event_kind_t kind;
    logic [6:0]  first_data;
    logic [6:0]  second_data;
  } parser_event_t;

endpackage

// ===== hw/rtl/mmp_decoder.sv =====
`timescale 1ns / 1ps

module mmp_decoder import mmp_pkg::*; (
  input  logic [7:0]    rx_byte,
  input  parser_state_t state,
  output parser_state_t state_next,
  output parser_event_t evt
);

  always_comb begin
    state_next      = state;
    evt.valid       = 1'b0;
    evt.kind        = EV_CTRL;
    evt.first_data  = state.held_first;
    evt.second_data = rx_byte[6:0];

    if (rx_byte[7]) begin
      // status byte: update kind, arm the data phase for two-data-byte messages
      case (rx_byte[7:4])
        STATUS_NOTE_ON: begin
          state_next.kind  = KIND_NOTE_ON;
          state_next.phase = PHASE_FIRST;
        end
        STATUS_NOTE_OFF: begin
          state_next.kind  = KIND_NOTE_OFF;
          state_next.phase = PHASE_FIRST;
        end
        STATUS_POLY_TOUCH, STATUS_CONTROL, STATUS_PITCH: begin
          state_next.kind  = KIND_CTRL;
          state_next.phase = PHASE_FIRST;
        end
        STATUS_PROGRAM, STATUS_CHAN_TOUCH: begin
          state_next.kind = KIND_UNIMPL;
        end
        STATUS_SYSTEM: begin
          // system common cancels running status, real-time leaves it alone
          if (!rx_byte[3]) begin
            state_next.kind = KIND_UNIMPL;
          end
        end
        default: begin
          state_next = state;
        end
      endcase
    end else begin
      // data byte
      case (state.phase)
        PHASE_FIRST: begin
          state_next.held_first = rx_byte[6:0];
          state_next.phase      = PHASE_SECOND;
        end
        PHASE_SECOND: begin
          state_next.phase = PHASE_FIRST;
          case (state.kind)
            KIND_NOTE_ON: begin
              evt.valid = 1'b1;
              // note on with zero velocity means note off
              evt.kind  = (rx_byte[6:0] == 7'd0) ? EV_NOTE_OFF : EV_NOTE_ON;
            end
            KIND_NOTE_OFF: begin
              evt.valid = 1'b1;
              evt.kind  = EV_NOTE_OFF;
            end
            KIND_CTRL: begin
              evt.valid = 1'b1;
              evt.kind  = EV_CTRL;
            end
            default: begin
              evt.valid = 1'b0;
            end
          endcase
        end
        default: begin
          state_next = state;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/midi_message_parser_unit.sv =====
`timescale 1ns / 1ps

// MIDI running-status parser.
// Input channel: in_valid / in_stall carry one received byte (rx_byte) per
// transaction; bit 7 set marks a status byte. Output channel: out_valid /
// out_stall carry one event (event_kind, first_data, second_data) for each
// completed pair of data bytes under a note on, note off or control status.
// A byte is registered on acceptance, decoded combinationally against the
// parser state, and its event is registered in the output register when the
// decode stage retires. One byte is taken every cycle while in_stall is low;
// the limit is the single decode stage between the input and output registers.
// When the receiver stalls with an event pending, bytes that make no event
// still pass through the decode stage; a byte that would make a second event
// waits in the input register and in_stall rises until the output drains.
// Reset (rst, synchronous) empties both registers, clears the message kind to
// none, sets the data phase to idle and clears the held first data byte, so
// data bytes before any status byte are dropped.
module midi_message_parser_unit import mmp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] event_kind,
  output logic [6:0] first_data,
  output logic [6:0] second_data
);

  logic          s1_valid;
  logic [7:0]    s1_byte;
  parser_state_t state;
  parser_state_t state_next;
  parser_event_t evt;
  event_kind_t   out_kind;
  logic          advance;

  mmp_decoder u_decoder (
    .rx_byte    (s1_byte),
    .state      (state),
    .state_next (state_next),
    .evt        (evt)
  );

  // decode stage retires unless it holds an event and the output is blocked
  assign advance  = s1_valid && (!evt.valid || !out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
    if (!in_stall && in_valid) begin
      s1_byte <= rx_byte;
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      state.kind       <= KIND_NONE;
      state.phase      <= PHASE_IDLE;
      state.held_first <= 7'd0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && evt.valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (advance && evt.valid) begin
      out_kind    <= evt.kind;
      first_data  <= evt.first_data;
      second_data <= evt.second_data;
    end
  end

  assign event_kind = out_kind;

`ifndef NO_ASSERTIONS
  // a byte is only taken into a full input register when that one retires
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && s1_valid) |-> advance)
    else $error("input register overrun");

  // a new output transaction comes only from a decoded event
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(advance && evt.valid))
    else $error("output valid without a decoded event");

  // an emitted event leaves the parser waiting for the next first data byte
  a_phase_after_event: assert property (@(posedge clk) disable iff (rst)
    (advance && evt.valid) |=> (state.phase == PHASE_FIRST))
    else $error("data phase wrong after event");

  // without any status byte seen, data stays ignored
  a_idle_without_kind: assert property (@(posedge clk) disable iff (rst)
    (state.kind == KIND_NONE) |-> (state.phase == PHASE_IDLE))
    else $error("data phase armed with no message kind");
`endif

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import mmp_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int ACTIVE_PER_PHASE = 240;
  localparam int LONG_HOLD = 80;

  typedef struct {
    event_kind_t kind;
    logic [6:0]  data1;
    logic [6:0]  data2;
  } midi_event_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] event_kind;
  logic [6:0] first_data;
  logic [6:0] second_data;

  // parser state as the predictor sees it
  msg_kind_t   cur_kind = KIND_NONE;
  data_phase_t cur_phase = PHASE_IDLE;
  logic [6:0]  held_data1 = 7'd0;

  midi_event_t pending_events[$];
  midi_event_t want_ev;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int long_hold_left = 0;
  int error_count = 0;
  int bytes_sent = 0;
  int active_bytes = 0;
  int events_checked = 0;
  int input_stall_cycles = 0;
  int cycle_count = 0;

  midi_message_parser_unit uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .rx_byte     (rx_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .event_kind  (event_kind),
    .first_data  (first_data),
    .second_data (second_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit and input back-pressure count
  always @(posedge clk) begin
    cycle_count++;
    if (in_valid && in_stall) input_stall_cycles++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d events still expected",
               cycle_count, pending_events.size());
      $display("midi_message_parser_unit: mismatch");
      $finish;
    end
  end

  // receiver: long hold-off when requested, random stalls otherwise
  always @(posedge clk) begin
    if (long_hold_left > 0) begin
      out_stall <= 1'b1;
      long_hold_left--;
    end else begin
      out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
    end
  end

  // compare each output transaction with the oldest expected event
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected event: kind %0d data1 %0d data2 %0d",
                 $time, event_kind, first_data, second_data);
        error_count++;
      end else begin
        want_ev = pending_events.pop_front();
        events_checked++;
        if (event_kind !== want_ev.kind) begin
          $display("%0t: event_kind expected %0d actual %0d",
                   $time, want_ev.kind, event_kind);
          error_count++;
        end
        if (first_data !== want_ev.data1) begin
          $display("%0t: first_data expected %0d actual %0d",
                   $time, want_ev.data1, first_data);
          error_count++;
        end
        if (second_data !== want_ev.data2) begin
          $display("%0t: second_data expected %0d actual %0d",
                   $time, want_ev.data2, second_data);
          error_count++;
        end
      end
    end
  end

  // running-status decode of one accepted byte
  task automatic parse_midi_byte(input logic [7:0] rx_value);
    midi_event_t ev;
    bytes_sent++;
    if (rx_value[7]) begin
      case (rx_value[7:4])
        STATUS_NOTE_ON: begin
          cur_kind = KIND_NOTE_ON;
          cur_phase = PHASE_FIRST;
        end
        STATUS_NOTE_OFF: begin
          cur_kind = KIND_NOTE_OFF;
          cur_phase = PHASE_FIRST;
        end
        STATUS_POLY_TOUCH, STATUS_CONTROL, STATUS_PITCH: begin
          cur_kind = KIND_CTRL;
          cur_phase = PHASE_FIRST;
        end
        STATUS_PROGRAM, STATUS_CHAN_TOUCH: cur_kind = KIND_UNIMPL;
        default: begin
          // system common cancels running status, real-time leaves it alone
          if (!rx_value[3]) cur_kind = KIND_UNIMPL;
        end
      endcase
      if (rx_value[7:3] != 5'b11111) active_bytes++;
    end else begin
      case (cur_phase)
        PHASE_FIRST: begin
          held_data1 = rx_value[6:0];
          cur_phase = PHASE_SECOND;
          active_bytes++;
        end
        PHASE_SECOND: begin
          cur_phase = PHASE_FIRST;
          active_bytes++;
          ev.data1 = held_data1;
          ev.data2 = rx_value[6:0];
          case (cur_kind)
            KIND_NOTE_ON: begin
              // zero velocity turns note on into note off
              ev.kind = (rx_value[6:0] == 7'd0) ? EV_NOTE_OFF : EV_NOTE_ON;
              pending_events.push_back(ev);
            end
            KIND_NOTE_OFF: begin
              ev.kind = EV_NOTE_OFF;
              pending_events.push_back(ev);
            end
            KIND_CTRL: begin
              ev.kind = EV_CTRL;
              pending_events.push_back(ev);
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  endtask

  // offer one byte, with random idle cycles first, and wait for acceptance
  task automatic send_byte(input logic [7:0] rx_value);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= rx_value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    parse_midi_byte(rx_value);
  endtask

  task automatic wait_for_events();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_events.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_data_byte();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) return 8'h00;
    if (pick == 1) return 8'h7F;
    return 8'($urandom_range(127));
  endfunction

  function automatic logic [7:0] rand_channel_status();
    logic [3:0] nib;
    case ($urandom_range(7))
      0: nib = STATUS_NOTE_OFF;
      1, 2: nib = STATUS_NOTE_ON;
      3: nib = STATUS_POLY_TOUCH;
      4: nib = STATUS_CONTROL;
      5: nib = STATUS_PITCH;
      6: nib = STATUS_PROGRAM;
      default: nib = STATUS_CHAN_TOUCH;
    endcase
    return {nib, 4'($urandom_range(15))};
  endfunction

  // one random message: mostly well formed, some system, broken or noise
  task automatic send_random_message();
    int pick;
    int pairs;
    pick = $urandom_range(99);
    if (pick < 75) begin
      send_byte(rand_channel_status());
      pairs = $urandom_range(1, 4);
      repeat (pairs) begin
        send_byte(rand_data_byte());
        if ($urandom_range(9) == 0) send_byte(8'($urandom_range(8'hF8, 8'hFF)));
        send_byte(rand_data_byte());
      end
    end else if (pick < 85) begin
      send_byte(8'($urandom_range(8'hF0, 8'hF7)));
      repeat ($urandom_range(3)) send_byte(rand_data_byte());
    end else if (pick < 93) begin
      send_byte(rand_channel_status());
      send_byte(rand_data_byte());
    end else begin
      send_byte(8'($urandom_range(255)));
    end
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // extremes and each status class, running status and mid-message cases
  task automatic test_directed();
    logic [7:0] seq[] = '{
      8'h00, 8'h7F,               // data before any status is dropped
      8'h90, 8'h3C, 8'h7F,        // note on
      8'h3C, 8'h00,               // running status, zero velocity
      8'h8F, 8'h00, 8'h7F,        // note off
      8'hA0, 8'h01, 8'h02,        // poly aftertouch as control
      8'hE3, 8'h40, 8'hF8, 8'h00, // pitch wheel with real-time inside
      8'hC0, 8'h05, 8'h06,        // program change: pair makes nothing
      8'hF0, 8'h11, 8'hFF,        // system common, then real-time
      8'h9A, 8'h55, 8'hBF, 8'h66, 8'h77 // status interrupts a pair
    };
    set_idling(0, 0);
    foreach (seq[i]) send_byte(seq[i]);
    send_byte(8'hD1);
    send_byte(8'h7F);
    send_byte(8'h7F);
    wait_for_events();
  endtask

  task automatic test_random_traffic();
    int target;
    int phase_pct[4][2] = '{'{0, 0}, '{46, 0}, '{0, 46}, '{21, 21}};
    for (int p = 0; p < 4; p++) begin
      set_idling(phase_pct[p][0], phase_pct[p][1]);
      target = active_bytes + ACTIVE_PER_PHASE;
      while (active_bytes < target) send_random_message();
    end
  endtask

  // receiver holds off while note data keeps coming, so the input stalls
  task automatic test_long_hold();
    set_idling(0, 0);
    long_hold_left = LONG_HOLD;
    send_byte(8'h95);
    repeat (20) begin
      send_byte(rand_data_byte());
      send_byte(rand_data_byte());
    end
    wait_for_events();
  endtask

  // sender pauses until all events are out, then running status resumes
  task automatic test_pause_resume();
    set_idling(21, 21);
    send_byte(8'hB2);
    send_byte(rand_data_byte());
    send_byte(rand_data_byte());
    wait_for_events();
    repeat (3) begin
      send_byte(rand_data_byte());
      send_byte(rand_data_byte());
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random_traffic();
    test_long_hold();
    test_pause_resume();

    wait_for_events();
    repeat (6) @(posedge clk);
    $display("%0d bytes sent (%0d not ignored), %0d events checked",
             bytes_sent, active_bytes, events_checked);
    $display("idling phases, long receiver hold-off (%0d input stall cycles), sender pause",
             input_stall_cycles);
    if (error_count == 0) begin
      $display("midi_message_parser_unit: match");
    end else begin
      $display("midi_message_parser_unit: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/mmp_pkg.sv
hw/rtl/mmp_decoder.sv
hw/rtl/midi_message_parser_unit.sv
test/testbench.sv
